[src/lr_pkg.sv]
// shared types and constants for the line rasterizer
// no dependencies; used by lr_front, lr_queue, lr_back and line_raster
package lr_pkg;

    localparam int COORD_W = 6;
    localparam int COLOR_W = 16;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 32;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [COLOR_W-1:0] color_t;

    // one classified line, ready for stepping
    typedef struct packed {
        logic   x_major;
        logic   minor_neg;
        logic   major_neg;
        coord_t major_start;
        coord_t minor_start;
        coord_t len;
        coord_t minor_mag;
        color_t color;
    } line_cmd_t;

endpackage

[src/lr_front.sv]
// request front end: clamps endpoints, picks the major axis, builds a line command
// depends on lr_pkg; feeds lr_queue
module lr_front #(
    parameter int GRID_SIZE = 64
) (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lr_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                               q_full,
    output logic                               q_push,
    output lr_pkg::line_cmd_t                  q_cmd
);

    localparam lr_pkg::coord_t MAX_COORD = lr_pkg::coord_t'(GRID_SIZE - 1);

    function automatic lr_pkg::coord_t clamp_coord(input lr_pkg::coord_t c);
        clamp_coord = (c > MAX_COORD) ? MAX_COORD : c;
    endfunction

    lr_pkg::coord_t sx, sy, ex, ey, adx, ady;
    logic signed [lr_pkg::COORD_W:0] dx, dy;
    logic x_major;

    always_comb begin
        sx = clamp_coord(s_tdata[5:0]);
        sy = clamp_coord(s_tdata[11:6]);
        ex = clamp_coord(s_tdata[17:12]);
        ey = clamp_coord(s_tdata[23:18]);
        dx = $signed({1'b0, ex}) - $signed({1'b0, sx});
        dy = $signed({1'b0, ey}) - $signed({1'b0, sy});
        adx = dx[lr_pkg::COORD_W] ? lr_pkg::coord_t'(-dx) : lr_pkg::coord_t'(dx);
        ady = dy[lr_pkg::COORD_W] ? lr_pkg::coord_t'(-dy) : lr_pkg::coord_t'(dy);
        x_major = adx >= ady;

        q_cmd.x_major     = x_major;
        q_cmd.major_neg   = x_major ? dx[lr_pkg::COORD_W] : dy[lr_pkg::COORD_W];
        q_cmd.minor_neg   = x_major ? dy[lr_pkg::COORD_W] : dx[lr_pkg::COORD_W];
        q_cmd.major_start = x_major ? sx : sy;
        q_cmd.minor_start = x_major ? sy : sx;
        q_cmd.len         = x_major ? adx : ady;
        q_cmd.minor_mag   = x_major ? ady : adx;
        q_cmd.color       = s_tdata[39:24];
    end

    // zero-length requests are taken and dropped
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && (q_cmd.len != '0);

endmodule

[src/lr_queue.sv]
// two-entry command queue between the front end and the stepper
// depends on lr_pkg
module lr_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  lr_pkg::line_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output lr_pkg::line_cmd_t pop_cmd
);

    lr_pkg::line_cmd_t slot_reg [2];
    logic wr_ptr_reg, wr_ptr_next;
    logic rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[src/lr_back.sv]
// line stepper: walks the major axis one cell per transfer, minor axis by remainder
// depends on lr_pkg; drives the result channel through an output register
module lr_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    input  lr_pkg::line_cmd_t               q_cmd,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lr_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);

    logic              active_reg, active_next;
    lr_pkg::line_cmd_t cmd_reg, cmd_next;
    lr_pkg::coord_t    maj_reg, maj_next;
    lr_pkg::coord_t    min_reg, min_next;
    lr_pkg::coord_t    err_reg, err_next;
    lr_pkg::coord_t    rem_reg, rem_next;
    logic              m_valid_reg, m_valid_next;
    lr_pkg::coord_t    out_x_reg, out_y_reg;
    lr_pkg::color_t    out_color_reg;
    logic              out_last_reg;

    logic out_free, emit, last;
    logic [lr_pkg::COORD_W:0] err_sum;

    assign out_free = !m_valid_reg || m_tready;
    assign emit     = active_reg && out_free;
    assign last     = rem_reg == lr_pkg::coord_t'(1);
    assign q_pop    = q_valid && (!active_reg || (emit && last));

    always_comb begin
        active_next = active_reg;
        cmd_next    = cmd_reg;
        maj_next    = maj_reg;
        min_next    = min_reg;
        err_next    = err_reg;
        rem_next    = rem_reg;
        err_sum     = {1'b0, err_reg} + {1'b0, cmd_reg.minor_mag};

        if (q_pop) begin
            active_next = 1'b1;
            cmd_next    = q_cmd;
            maj_next    = q_cmd.major_start;
            min_next    = q_cmd.minor_start;
            err_next    = '0;
            rem_next    = q_cmd.len;
        end else if (emit && last) begin
            active_next = 1'b0;
        end else if (emit) begin
            rem_next = rem_reg - lr_pkg::coord_t'(1);
            maj_next = cmd_reg.major_neg ? maj_reg - lr_pkg::coord_t'(1)
                                         : maj_reg + lr_pkg::coord_t'(1);
            if (!cmd_reg.minor_neg) begin
                // err tracks the floor remainder
                if (err_sum >= {1'b0, cmd_reg.len}) begin
                    err_next = lr_pkg::coord_t'(err_sum - {1'b0, cmd_reg.len});
                    min_next = min_reg + lr_pkg::coord_t'(1);
                end else begin
                    err_next = lr_pkg::coord_t'(err_sum);
                end
            end else begin
                // err tracks the ceiling slack, minor moves down on underflow
                if (err_reg >= cmd_reg.minor_mag) begin
                    err_next = err_reg - cmd_reg.minor_mag;
                end else begin
                    err_next = err_reg + cmd_reg.len - cmd_reg.minor_mag;
                    min_next = min_reg - lr_pkg::coord_t'(1);
                end
            end
        end

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        maj_reg <= maj_next;
        min_reg <= min_next;
        err_reg <= err_next;
        rem_reg <= rem_next;
        if (emit) begin
            out_x_reg     <= cmd_reg.x_major ? maj_reg : min_reg;
            out_y_reg     <= cmd_reg.x_major ? min_reg : maj_reg;
            out_color_reg <= cmd_reg.color;
            out_last_reg  <= last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, out_color_reg, out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_rem_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> rem_reg != '0)
        else $error("active line with no cells left");

    a_err_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> err_reg < cmd_reg.len)
        else $error("remainder out of range");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg && !out_free) |=> $stable(rem_reg) && $stable(maj_reg))
        else $error("stepper advanced while output stalled");

    a_pop_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (!active_reg || last))
        else $error("command taken while a line is in progress");
`endif

endmodule

[src/line_raster.sv]
// top level of the line rasterizer: front end, command queue and stepper
// depends on lr_pkg, lr_front, lr_queue, lr_back
//
// Each request transfer carries two endpoints and a color; the block emits the cells
// of the line from the start toward (not including) the end, one result transfer
// per clock when the output is not stalled, with tlast on the final cell. A line
// of major-axis length n yields n cells, at most GRID_SIZE-1. A request passes
// through the queue slot, the stepper registers and the output register before
// its first cell appears, and back-to-back lines leave no gap. Requests with
// equal endpoints are taken and produce nothing. Up to two classified lines wait
// in the queue while the stepper works.
module line_raster #(
    parameter int GRID_SIZE = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], color[39:24]
    input  logic [lr_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // cell_x[5:0], cell_y[11:6], cell_color[27:12], zero[31:28]
    output logic [lr_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                              m_tlast
);

    logic              q_full, q_push, q_pop, q_not_empty;
    lr_pkg::line_cmd_t push_cmd, pop_cmd;

    lr_front #(
        .GRID_SIZE(GRID_SIZE)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    lr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_cmd   (pop_cmd)
    );

    lr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_cmd    (pop_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
